FILE: rtl/assert_macros.svh
// Assertion macros shared by the RTL; they compile away under SYNTHESIS.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication, checked at every rising edge out of reset.
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("same-cycle implication failed");
// Next-cycle implication, checked at every rising edge out of reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("next-cycle implication failed");
`else
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

FILE: rtl/wftol_pkg.sv
// Package: constants, types and helper functions of the waveform lag core.
package wftol_pkg;

	localparam int SAMPLE_BITS    = 16;
	localparam int EXTRA_BITS     = 8;
	localparam int STATE_BITS     = SAMPLE_BITS + EXTRA_BITS;
	localparam int COEF_BITS      = 16;
	localparam int PHASE_BITS     = 16;
	localparam int TIME_BITS      = 32;
	localparam int SINE_DEPTH     = 256;
	localparam int SINE_IDX_BITS  = $clog2(SINE_DEPTH);
	localparam int SINE_BITS      = 17;
	localparam int SINE_FRAC_BITS = 15;
	localparam int NUM_CHAINS     = 2;
	localparam int NUM_SECTIONS   = 3;
	localparam int QUEUE_DEPTH    = 2;

	// Shared front multiplier: 33-bit time or level by 17-bit increment or sine.
	localparam int MUL_A_BITS = TIME_BITS + 1;
	localparam int MUL_B_BITS = SINE_BITS;
	localparam int MUL_P_BITS = MUL_A_BITS + MUL_B_BITS;

	localparam logic signed [MUL_P_BITS-1:0] SAT_MAX = MUL_P_BITS'(2 ** (SAMPLE_BITS - 1) - 1);
	localparam logic signed [MUL_P_BITS-1:0] SAT_MIN = MUL_P_BITS'(-(2 ** (SAMPLE_BITS - 1)));

	localparam int MODE_BITS = 2;
	localparam logic [MODE_BITS-1:0] MODE_SINE   = 2'd0;
	localparam logic [MODE_BITS-1:0] MODE_STEP   = 2'd1;
	localparam logic [MODE_BITS-1:0] MODE_RAMP   = 2'd2;
	localparam logic [MODE_BITS-1:0] MODE_UNUSED = 2'd3;

	localparam int CFG_IDX_BITS  = 3;
	localparam int CFG_DATA_BITS = 16;
	localparam logic [CFG_IDX_BITS-1:0] REG_WAVE_MODE   = 3'd0;
	localparam logic [CFG_IDX_BITS-1:0] REG_LEVEL       = 3'd1;
	localparam logic [CFG_IDX_BITS-1:0] REG_INCREMENT   = 3'd2;
	localparam logic [CFG_IDX_BITS-1:0] REG_LEAD        = 3'd3;
	localparam logic [CFG_IDX_BITS-1:0] REG_COEF_FIRST  = 3'd4;
	localparam logic [CFG_IDX_BITS-1:0] REG_COEF_SECOND = 3'd5;
	localparam logic [CFG_IDX_BITS-1:0] REG_COEF_THIRD  = 3'd6;

	localparam logic [MODE_BITS-1:0]          RST_WAVE_MODE   = MODE_SINE;
	localparam logic signed [SAMPLE_BITS-1:0] RST_LEVEL       = 16'sd16384;
	localparam logic signed [SAMPLE_BITS-1:0] RST_INCREMENT   = 16'sd256;
	localparam logic signed [SAMPLE_BITS-1:0] RST_LEAD        = 16'sd0;
	localparam logic [COEF_BITS-1:0]          RST_COEF_FIRST  = 16'd4096;
	localparam logic [COEF_BITS-1:0]          RST_COEF_SECOND = 16'd21845;
	localparam logic [COEF_BITS-1:0]          RST_COEF_THIRD  = 16'd59578;

	// Quarter-wave polynomial constants, Q30
	localparam longint Q30_ONE = 64'sd1073741824;
	localparam longint POLY_A  = 64'sd1686629713;
	localparam longint POLY_B  = 2 * POLY_A - (5 * Q30_ONE) / 2;
	localparam longint POLY_C  = POLY_A - (3 * Q30_ONE) / 2;

	typedef logic signed [SAMPLE_BITS-1:0] sample_t;
	typedef logic signed [STATE_BITS-1:0]  stage_t;

	typedef struct packed {
		logic [MODE_BITS-1:0]  wave_mode;
		sample_t               level;
		sample_t               increment;
		sample_t               lead;
		logic [COEF_BITS-1:0]  coef_first;
		logic [COEF_BITS-1:0]  coef_second;
		logic [COEF_BITS-1:0]  coef_third;
	} cfg_t;

	// Work handed from the front to the filter sections.
	typedef struct packed {
		logic    restart;
		logic    has_shift;
		sample_t gen;
		sample_t shifted;
	} tick_t;

	typedef struct packed {
		sample_t generated;
		sample_t response;
		sample_t shifted_response;
	} result_t;

	// Sine table entry i, Q15, evaluated at elaboration.
	function automatic logic signed [SINE_BITS-1:0] sine_entry(input int unsigned i);
		longint p;
		longint quad;
		longint x;
		longint x2;
		longint inner;
		longint mid;
		longint s;
		p = (longint'(i) * 65536) / SINE_DEPTH;
		p = p & 64'hFFFF;
		quad = p >>> 14;
		x = (p & 64'h3FFF) * 2;
		if (quad[0])
			x = 32768 - x;
		x2 = x * x;
		inner = POLY_B - ((POLY_C * x2) >>> 30);
		mid = POLY_A - ((inner * x2) >>> 30);
		s = (mid * x) >>> 30;
		if (quad[1])
			s = -s;
		return s[SINE_BITS-1:0];
	endfunction

	// Clamp a wide signed value to the sample range.
	function automatic sample_t sat_sample(input logic signed [MUL_P_BITS-1:0] v);
		sample_t r;
		if (v > SAT_MAX)
			r = SAT_MAX[SAMPLE_BITS-1:0];
		else if (v < SAT_MIN)
			r = SAT_MIN[SAMPLE_BITS-1:0];
		else
			r = v[SAMPLE_BITS-1:0];
		return r;
	endfunction

endpackage

FILE: rtl/wftol_queue.sv
// Small register FIFO used between front and back and at the result side.
module wftol_queue #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wr_data,
	output logic             full,
	input  logic             pop,
	output logic [WIDTH-1:0] rd_data,
	output logic             empty
);
	localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_BITS = $clog2(DEPTH + 1);

	logic [WIDTH-1:0]    mem_q [DEPTH];
	logic [PTR_BITS-1:0] wr_ptr_q;
	logic [PTR_BITS-1:0] rd_ptr_q;
	logic [CNT_BITS-1:0] count_q;
	logic                do_push;
	logic                do_pop;

	assign full    = (count_q == CNT_BITS'(DEPTH));
	assign empty   = (count_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rd_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_BITS'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_BITS'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

endmodule

FILE: rtl/wftol_front.sv
// Front: accepts ticks, keeps the tick count and generates both waveforms.
module wftol_front (
	input  logic              clk,
	input  logic              arst_n,
	input  wftol_pkg::cfg_t   cfg,
	input  logic              push,
	input  logic              restart,
	output logic              busy,
	output wftol_pkg::tick_t  item,
	output logic              item_valid,
	input  logic              item_full
);
	import wftol_pkg::*;

	localparam logic [2:0] F_IDLE = 3'd0;
	localparam logic [2:0] F_TIME = 3'd1;
	localparam logic [2:0] F_GEN  = 3'd2;
	localparam logic [2:0] F_SINA = 3'd3;
	localparam logic [2:0] F_SINB = 3'd4;
	localparam logic [2:0] F_PUSH = 3'd5;

	logic [2:0]                     state_q;
	logic [TIME_BITS-1:0]           n_q;
	logic                           restart_q;
	logic [PHASE_BITS-1:0]          phase_q;
	logic signed [MUL_P_BITS-1:0]   mul_q;
	sample_t                        gen_q;
	sample_t                        shift_q;

	logic signed [SINE_BITS-1:0]    sine_rom [SINE_DEPTH];
	logic [PHASE_BITS-1:0]          phase_sel;
	logic [SINE_IDX_BITS-1:0]       sine_idx;
	logic signed [MUL_A_BITS-1:0]   mul_a;
	logic signed [MUL_B_BITS-1:0]   mul_b;
	logic signed [MUL_P_BITS-1:0]   mul_p;
	logic signed [MUL_P_BITS-1:0]   base;
	logic signed [MUL_P_BITS-1:0]   base_lead;
	logic signed [MUL_P_BITS-1:0]   sine_scaled;
	logic                           mode_valid;

	for (genvar g = 0; g < SINE_DEPTH; g++) begin : g_rom
		assign sine_rom[g] = sine_entry(g);
	end

	// Main phase comes straight from the product; shifted phase adds the lead.
	assign phase_sel = (state_q == F_GEN) ? mul_q[PHASE_BITS-1:0]
	                                      : phase_q + $unsigned(cfg.lead);
	assign sine_idx  = phase_sel[PHASE_BITS-1 -: SINE_IDX_BITS];

	always_comb begin
		if (state_q == F_TIME) begin
			mul_a = $signed({1'b0, n_q});
			mul_b = MUL_B_BITS'(cfg.increment);
		end else begin
			mul_a = MUL_A_BITS'(cfg.level);
			mul_b = sine_rom[sine_idx];
		end
	end

	assign mul_p       = mul_a * mul_b;
	assign base        = mul_q + MUL_P_BITS'(cfg.level);
	assign base_lead   = base + MUL_P_BITS'(cfg.lead);
	assign sine_scaled = mul_q >>> SINE_FRAC_BITS;
	assign mode_valid  = (cfg.wave_mode == MODE_SINE) || (cfg.wave_mode == MODE_STEP) ||
	                     (cfg.wave_mode == MODE_RAMP);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= F_IDLE;
			n_q     <= '0;
		end else begin
			case (state_q)
				F_IDLE: begin
					if (push) begin
						if (restart) begin
							n_q     <= '0;
							state_q <= F_PUSH;
						end else if (mode_valid) begin
							state_q <= F_TIME;
						end
					end
				end
				F_TIME: begin
					n_q     <= n_q + 1'b1;
					state_q <= F_GEN;
				end
				F_GEN: begin
					state_q <= (cfg.wave_mode == MODE_SINE) ? F_SINA : F_PUSH;
				end
				F_SINA: state_q <= F_SINB;
				F_SINB: state_q <= F_PUSH;
				F_PUSH: begin
					if (!item_full) begin
						state_q <= F_IDLE;
					end
				end
				default: state_q <= F_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == F_IDLE && push) begin
			restart_q <= restart;
		end
		if (state_q == F_TIME || state_q == F_GEN || state_q == F_SINA) begin
			mul_q <= mul_p;
		end
		if (state_q == F_GEN) begin
			phase_q <= mul_q[PHASE_BITS-1:0];
			case (cfg.wave_mode)
				MODE_STEP: begin
					gen_q   <= cfg.level;
					shift_q <= '0;
				end
				MODE_RAMP: begin
					gen_q   <= sat_sample(base);
					shift_q <= sat_sample(base_lead);
				end
				default: ;
			endcase
		end
		if (state_q == F_SINA) begin
			gen_q <= sat_sample(sine_scaled);
		end
		if (state_q == F_SINB) begin
			shift_q <= sat_sample(sine_scaled);
		end
	end

	assign busy            = (state_q != F_IDLE);
	assign item_valid      = (state_q == F_PUSH);
	assign item.restart    = restart_q;
	assign item.has_shift  = (cfg.wave_mode != MODE_STEP);
	assign item.gen        = gen_q;
	assign item.shifted    = shift_q;

endmodule

FILE: rtl/wftol_back.sv
// Back: runs both three-section lag chains on one shared multiplier.
module wftol_back (
	input  logic               clk,
	input  logic               arst_n,
	input  wftol_pkg::cfg_t    cfg,
	input  wftol_pkg::tick_t   tick,
	input  logic               tick_empty,
	output logic               tick_pop,
	output wftol_pkg::result_t res,
	output logic               res_valid,
	input  logic               res_full
);
	import wftol_pkg::*;

	localparam logic [1:0] B_IDLE = 2'd0;
	localparam logic [1:0] B_RUN  = 2'd1;
	localparam logic [1:0] B_OUT  = 2'd2;

	localparam int STEPS     = NUM_CHAINS * NUM_SECTIONS;
	localparam int STEP_BITS = $clog2(STEPS + 1);
	localparam int SEC_BITS  = $clog2(NUM_SECTIONS);
	localparam int DIFF_BITS = STATE_BITS + 1;
	localparam int PROD_BITS = DIFF_BITS + COEF_BITS + 1;

	logic [1:0]                   state_q;
	logic [STEP_BITS-1:0]         step_q;
	tick_t                        cur_q;
	stage_t                       stage_q [NUM_CHAINS][NUM_SECTIONS];
	logic                         b_valid_s2;
	logic signed [PROD_BITS-1:0]  prod_s2;
	stage_t                       y_s2;
	logic                         chain_s2;
	logic [SEC_BITS-1:0]          sec_s2;
	stage_t                       last_q;

	logic                         a_active;
	logic                         chain_a;
	logic [SEC_BITS-1:0]          sec_a;
	stage_t                       y_a;
	stage_t                       x_a;
	logic signed [DIFF_BITS-1:0]  diff_a;
	logic [COEF_BITS-1:0]         coef_a;
	logic signed [PROD_BITS-1:0]  prod_a;
	stage_t                       upd;
	logic                         b_write;

	// Steps alternate main and shifted chain, so each later section's input (last_q)
	// holds the update-stage result of the same chain's previous section.
	assign a_active = (state_q == B_RUN) && (step_q != STEP_BITS'(STEPS));
	assign chain_a  = step_q[0];
	assign sec_a    = step_q[STEP_BITS-1:1];
	assign y_a      = stage_q[chain_a][sec_a];
	assign x_a      = (sec_a == '0)
		? {(chain_a ? cur_q.shifted : cur_q.gen), {EXTRA_BITS{1'b0}}} : last_q;
	assign diff_a   = DIFF_BITS'(x_a) - DIFF_BITS'(y_a);

	always_comb begin
		case (sec_a)
			2'd0:    coef_a = cfg.coef_first;
			2'd1:    coef_a = cfg.coef_second;
			default: coef_a = cfg.coef_third;
		endcase
	end

	assign prod_a  = $signed({1'b0, coef_a}) * diff_a;
	assign upd     = y_s2 + STATE_BITS'(prod_s2 >>> COEF_BITS);
	assign b_write = b_valid_s2 && (!chain_s2 || cur_q.has_shift);

	assign tick_pop = (state_q == B_IDLE) && !tick_empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= B_IDLE;
			step_q     <= '0;
			b_valid_s2 <= 1'b0;
			for (int c = 0; c < NUM_CHAINS; c++) begin
				for (int s = 0; s < NUM_SECTIONS; s++) begin
					stage_q[c][s] <= '0;
				end
			end
		end else begin
			b_valid_s2 <= a_active;
			if (b_write) begin
				stage_q[chain_s2][sec_s2] <= upd;
			end
			case (state_q)
				B_IDLE: begin
					if (!tick_empty) begin
						if (tick.restart) begin
							for (int c = 0; c < NUM_CHAINS; c++) begin
								for (int s = 0; s < NUM_SECTIONS; s++) begin
									stage_q[c][s] <= '0;
								end
							end
						end else begin
							step_q  <= '0;
							state_q <= B_RUN;
						end
					end
				end
				B_RUN: begin
					if (step_q == STEP_BITS'(STEPS)) begin
						state_q <= B_OUT;
					end else begin
						step_q <= step_q + 1'b1;
					end
				end
				B_OUT: begin
					if (!res_full) begin
						state_q <= B_IDLE;
					end
				end
				default: state_q <= B_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (tick_pop) begin
			cur_q <= tick;
		end
		if (a_active) begin
			prod_s2  <= prod_a;
			y_s2     <= y_a;
			chain_s2 <= chain_a;
			sec_s2   <= sec_a;
		end
		if (b_valid_s2) begin
			last_q <= upd;
		end
	end

	assign res_valid     = (state_q == B_OUT);
	assign res.generated = cur_q.gen;
	assign res.response  = SAMPLE_BITS'(stage_q[0][NUM_SECTIONS-1] >>> EXTRA_BITS);
	assign res.shifted_response = cur_q.has_shift
		? SAMPLE_BITS'(stage_q[1][NUM_SECTIONS-1] >>> EXTRA_BITS) : '0;

endmodule

FILE: rtl/waveform_through_third_order_lag_core.sv
// Top level: sine/step/ramp generator feeding two third-order lag chains.
// The section unit sets the tick rate: one multiplier runs the six sections of a tick in turn.
// The front holds full through TIME, GEN, SINA and SINB (sine only) and PUSH after a tick, or
// PUSH alone after a restart; results pass the mid queue, back and result queue to the ports.
// Reset: arst_n sets register defaults, clears time count and sections at once; no clearing pass.
`include "assert_macros.svh"

module waveform_through_third_order_lag_core #(
	parameter int QUEUE_DEPTH = wftol_pkg::QUEUE_DEPTH
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   push,
	input  logic                                   restart,
	output logic                                   full,
	output logic                                   empty,
	input  logic                                   pop,
	output logic signed [wftol_pkg::SAMPLE_BITS-1:0] generated,
	output logic signed [wftol_pkg::SAMPLE_BITS-1:0] response,
	output logic signed [wftol_pkg::SAMPLE_BITS-1:0] shifted_response,
	input  logic                                   wr_en,
	input  logic [wftol_pkg::CFG_IDX_BITS-1:0]     wr_index,
	input  logic [wftol_pkg::CFG_DATA_BITS-1:0]    wr_data
);
	import wftol_pkg::*;

	// Configuration registers, shared by front and back
	cfg_t    cfg_q;

	// Front to back queue
	tick_t   front_item;
	logic    front_valid;
	logic    front_busy;
	logic    mid_full;
	logic    mid_empty;
	tick_t   mid_head;
	logic    tick_pop;

	// Back to result queue
	result_t back_res;
	logic    back_valid;
	logic    out_full;
	result_t out_head;

	// Hold registers between writes; drop writes beyond the register list.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.wave_mode   <= RST_WAVE_MODE;
			cfg_q.level       <= RST_LEVEL;
			cfg_q.increment   <= RST_INCREMENT;
			cfg_q.lead        <= RST_LEAD;
			cfg_q.coef_first  <= RST_COEF_FIRST;
			cfg_q.coef_second <= RST_COEF_SECOND;
			cfg_q.coef_third  <= RST_COEF_THIRD;
		end else if (wr_en) begin
			case (wr_index)
				REG_WAVE_MODE:   cfg_q.wave_mode   <= wr_data[MODE_BITS-1:0];
				REG_LEVEL:       cfg_q.level       <= $signed(wr_data[SAMPLE_BITS-1:0]);
				REG_INCREMENT:   cfg_q.increment   <= $signed(wr_data[SAMPLE_BITS-1:0]);
				REG_LEAD:        cfg_q.lead        <= $signed(wr_data[SAMPLE_BITS-1:0]);
				REG_COEF_FIRST:  cfg_q.coef_first  <= wr_data[COEF_BITS-1:0];
				REG_COEF_SECOND: cfg_q.coef_second <= wr_data[COEF_BITS-1:0];
				REG_COEF_THIRD:  cfg_q.coef_third  <= wr_data[COEF_BITS-1:0];
				default: ;
			endcase
		end
	end

	// Front: takes a tick whenever it is idle, independent of the result side.
	wftol_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.push       (push),
		.restart    (restart),
		.busy       (front_busy),
		.item       (front_item),
		.item_valid (front_valid),
		.item_full  (mid_full)
	);

	assign full = front_busy;

	// Decouple generation from filtering so either side may stall alone.
	wftol_queue #(
		.WIDTH ($bits(tick_t)),
		.DEPTH (QUEUE_DEPTH)
	) u_mid_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (front_valid),
		.wr_data (front_item),
		.full    (mid_full),
		.pop     (tick_pop),
		.rd_data (mid_head),
		.empty   (mid_empty)
	);

	// Back: restarts clear the sections, other ticks run both chains; step mode holds the shifted one.
	wftol_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.tick       (mid_head),
		.tick_empty (mid_empty),
		.tick_pop   (tick_pop),
		.res        (back_res),
		.res_valid  (back_valid),
		.res_full   (out_full)
	);

	// Result queue: the oldest result sits on the ports while empty is low.
	wftol_queue #(
		.WIDTH ($bits(result_t)),
		.DEPTH (QUEUE_DEPTH)
	) u_out_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (back_valid),
		.wr_data (back_res),
		.full    (out_full),
		.pop     (pop),
		.rd_data (out_head),
		.empty   (empty)
	);

	assign generated        = out_head.generated;
	assign response         = out_head.response;
	assign shifted_response = out_head.shifted_response;

	// An accepted restart item must make the front busy and raise full on its way to the back part.
	`ASSERT_NEXT(a_restart_forwarded, clk, arst_n, push && !full && restart, full)
	// A tick in the unused mode is dropped at once and leaves the count alone.
	`ASSERT_NEXT(a_unused_mode_drop, clk, arst_n,
		push && !full && !restart && cfg_q.wave_mode == MODE_UNUSED, !full)
	// The back part only takes work the queue really holds.
	`ASSERT_IMPLY(a_pop_has_item, clk, arst_n, tick_pop, !mid_empty)

endmodule

FILE: bench/tb_waveform_through_third_order_lag_core.sv
// Testbench of the waveform lag core: directed table, then random phases checked by a model.
`timescale 1ns / 1ps

module tb_waveform_through_third_order_lag_core;
	import wftol_pkg::*;

	// Run control
	localparam int SETTLE_CYCLES  = 40;      // quiet time after the last owed sample
	localparam int LONG_HOLD      = 300;     // receiver hold-off that backs the core up
	localparam int CYCLE_LIMIT    = 500000;
	localparam int RANDOM_PHASES  = 32;
	localparam int PHASE_ITEMS    = 65;
	localparam int UNUSED_ITEMS   = 4;
	localparam int HOLD_PHASE     = 5;
	localparam int CALM_PHASES    = 3;

	// Index past the end of the register map; writes to it must be dropped.
	localparam logic [CFG_IDX_BITS-1:0] REG_UNMAPPED = 3'd7;

	// Quarter-wave polynomial, Q30
	localparam longint Q30_UNIT = 64'sd1073741824;
	localparam longint POLY_K1  = 64'sd1686629713;
	localparam longint POLY_K2  = 2 * POLY_K1 - (5 * Q30_UNIT) / 2;
	localparam longint POLY_K3  = POLY_K1 - (3 * Q30_UNIT) / 2;
	localparam longint SAMPLE_HI = 64'sd32767;
	localparam longint SAMPLE_LO = -64'sd32768;

	localparam result_t ALL_ZERO = '0;

	typedef enum logic [1:0] {OP_TICK, OP_RESTART, OP_WRITE} op_t;

	typedef struct {
		op_t                      op;
		logic [CFG_IDX_BITS-1:0]  idx;
		logic [CFG_DATA_BITS-1:0] data;
		bit                       typed;
		result_t                  res;
	} stim_row_t;

	typedef struct {
		bit      typed;
		result_t res;
	} typed_slot_t;

	logic                      clk;
	logic                      arst_n;
	logic                      push;
	logic                      restart;
	logic                      full;
	logic                      empty;
	logic                      pop;
	sample_t                   generated;
	sample_t                   response;
	sample_t                   shifted_response;
	logic                      wr_en;
	logic [CFG_IDX_BITS-1:0]   wr_index;
	logic [CFG_DATA_BITS-1:0]  wr_data;

	waveform_through_third_order_lag_core uut (
		.clk              (clk),
		.arst_n           (arst_n),
		.push             (push),
		.restart          (restart),
		.full             (full),
		.empty            (empty),
		.pop              (pop),
		.generated        (generated),
		.response         (response),
		.shifted_response (shifted_response),
		.wr_en            (wr_en),
		.wr_index         (wr_index),
		.wr_data          (wr_data)
	);

	// ---------------------------------------------------------------------
	// Model of the core: its own register copy, tick count and lag states
	// ---------------------------------------------------------------------
	longint          sine_lut [SINE_DEPTH];
	logic [1:0]      cfg_mode;
	longint          cfg_level;
	longint          cfg_increment;
	longint          cfg_lead;
	longint          cfg_coef [3];
	logic [31:0]     tick_count;
	longint          lag_state [2][3];   // [0] main chain, [1] shifted chain

	result_t         pending_samples [$];   // samples the core still owes us
	typed_slot_t     typed_samples [$];     // hand-typed answers, one per offered item
	stim_row_t       directed_rows [$];

	int              mismatches;
	int              cycles;
	bit              calm;        // no idling on either side
	bit              hold_req;    // ask the receiver for a long hold-off

	function automatic void build_sine_lut();
		longint p;
		longint quad;
		longint x;
		longint x2;
		longint t;
		longint s;
		for (int i = 0; i < SINE_DEPTH; i++) begin
			p = ((longint'(i) * 65536) / SINE_DEPTH) & 64'hFFFF;
			quad = p >>> 14;
			x = (p & 64'h3FFF) * 2;
			// odd quadrants run the quarter wave backward
			if (quad[0])
				x = 32768 - x;
			x2 = x * x;
			t = POLY_K2 - ((POLY_K3 * x2) >>> 30);
			t = POLY_K1 - ((t * x2) >>> 30);
			s = (t * x) >>> 30;
			if (quad[1])
				s = -s;
			sine_lut[i] = s;
		end
	endfunction

	function automatic longint clamp_sample(input longint v);
		if (v > SAMPLE_HI)
			return SAMPLE_HI;
		if (v < SAMPLE_LO)
			return SAMPLE_LO;
		return v;
	endfunction

	function automatic longint sine_at(input logic [15:0] phase);
		longint idx;
		idx = (longint'(phase) * SINE_DEPTH) >>> 16;
		return clamp_sample((cfg_level * sine_lut[idx]) >>> 15);
	endfunction

	// One section: y += floor(c * (x - y) / 2^16)
	function automatic longint lag_section(input longint y, input longint x, input longint c);
		return y + ((c * (x - y)) >>> 16);
	endfunction

	function automatic longint run_lags(input int chain, input longint sample);
		lag_state[chain][0] = lag_section(lag_state[chain][0], sample * 256, cfg_coef[0]);
		lag_state[chain][1] = lag_section(lag_state[chain][1], lag_state[chain][0], cfg_coef[1]);
		lag_state[chain][2] = lag_section(lag_state[chain][2], lag_state[chain][1], cfg_coef[2]);
		return lag_state[chain][2] >>> EXTRA_BITS;
	endfunction

	function automatic void load_register(input logic [CFG_IDX_BITS-1:0] idx,
			input logic [CFG_DATA_BITS-1:0] data);
		case (idx)
			REG_WAVE_MODE:   cfg_mode = data[MODE_BITS-1:0];
			REG_LEVEL:       cfg_level = longint'($signed(data));
			REG_INCREMENT:   cfg_increment = longint'($signed(data));
			REG_LEAD:        cfg_lead = longint'($signed(data));
			REG_COEF_FIRST:  cfg_coef[0] = longint'(data);
			REG_COEF_SECOND: cfg_coef[1] = longint'(data);
			REG_COEF_THIRD:  cfg_coef[2] = longint'(data);
			default: ;
		endcase
	endfunction

	// Advance the model by one accepted item; returns 1 when it yields a sample.
	function automatic bit predict_sample(input logic restart_bit, output result_t r);
		logic [31:0] n;
		logic [31:0] phase32;
		logic [15:0] lead_phase;
		longint      gen;
		longint      shf;
		longint      resp;
		longint      sresp;
		longint      base;
		n = tick_count;
		r = '0;
		sresp = 0;
		if (restart_bit) begin
			tick_count = '0;
			for (int c = 0; c < 2; c++)
				for (int s = 0; s < 3; s++)
					lag_state[c][s] = 0;
			return 1'b0;
		end
		case (cfg_mode)
			MODE_SINE: begin
				phase32 = n * 32'(cfg_increment);
				lead_phase = phase32[15:0] + cfg_lead[15:0];
				gen = sine_at(phase32[15:0]);
				shf = sine_at(lead_phase);
				resp = run_lags(0, gen);
				sresp = run_lags(1, shf);
			end
			MODE_STEP: begin
				// shifted chain holds its state
				gen = clamp_sample(cfg_level);
				resp = run_lags(0, gen);
			end
			MODE_RAMP: begin
				base = cfg_level + cfg_increment * longint'(n);
				gen = clamp_sample(base);
				shf = clamp_sample(base + cfg_lead);
				resp = run_lags(0, gen);
				sresp = run_lags(1, shf);
			end
			default: return 1'b0;   // unused mode: nothing happens, count holds
		endcase
		tick_count = n + 32'd1;
		r.generated = gen[15:0];
		r.response = resp[15:0];
		r.shifted_response = sresp[15:0];
		return 1'b1;
	endfunction

	// ---------------------------------------------------------------------
	// Clock, cycle limit
	// ---------------------------------------------------------------------
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("tb_waveform_through_third_order_lag_core failed");
			$finish;
		end
	end

	// ---------------------------------------------------------------------
	// Monitor: check popped samples, track writes and accepted items
	// ---------------------------------------------------------------------
	always @(posedge clk) begin
		result_t     got;
		result_t     want;
		result_t     predicted;
		typed_slot_t slot;
		if (arst_n) begin
			if (pop && !empty) begin
				got.generated = generated;
				got.response = response;
				got.shifted_response = shifted_response;
				if (pending_samples.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("%0t: sample with nothing pending: gen %0d resp %0d shifted %0d",
							$realtime, got.generated, got.response, got.shifted_response);
				end else begin
					want = pending_samples.pop_front();
					if (got.generated !== want.generated || got.response !== want.response
							|| got.shifted_response !== want.shifted_response) begin
						mismatches++;
						if (mismatches <= 10)
							$display("%0t: want gen %0d resp %0d shifted %0d, got %0d %0d %0d",
								$realtime, want.generated, want.response,
								want.shifted_response, got.generated, got.response,
								got.shifted_response);
					end
				end
			end
			if (wr_en)
				load_register(wr_index, wr_data);
			if (push && !full) begin
				slot = typed_samples.pop_front();
				if (predict_sample(restart, predicted))
					pending_samples.push_back(slot.typed ? slot.res : predicted);
			end
		end
	end

	// ---------------------------------------------------------------------
	// Receiver: random stall bursts, one long hold-off on request
	// ---------------------------------------------------------------------
	initial begin
		pop <= 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (hold_req) begin
				// hold long enough that the core fills and raises full
				pop <= 1'b0;
				repeat (LONG_HOLD) @(posedge clk);
				hold_req = 1'b0;
			end else if (!calm && $urandom_range(0, 5) == 0) begin
				pop <= 1'b0;
				repeat ($urandom_range(1, 8) - 1) @(posedge clk);
			end else begin
				pop <= 1'b1;
			end
		end
	end

	// ---------------------------------------------------------------------
	// Sender tasks; each returns right after a rising edge
	// ---------------------------------------------------------------------
	// Offer one item and hold it until taken; push stays high for the next one.
	task automatic send_item(input bit restart_bit, input bit typed, input result_t typed_res);
		typed_slot_t slot;
		slot.typed = typed;
		slot.res = typed_res;
		typed_samples.push_back(slot);
		if (!calm && $urandom_range(0, 5) == 0) begin
			push <= 1'b0;
			repeat ($urandom_range(1, 8)) @(posedge clk);
		end
		push <= 1'b1;
		restart <= restart_bit;
		@(posedge clk);
		while (full) @(posedge clk);
	endtask

	// Drop push and wait until the core owes nothing and has gone quiet.
	task automatic settle();
		push <= 1'b0;
		@(posedge clk);
		while (pending_samples.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx,
			input logic [CFG_DATA_BITS-1:0] data);
		wr_en <= 1'b1;
		wr_index <= idx;
		wr_data <= data;
		@(posedge clk);
		wr_en <= 1'b0;
		@(posedge clk);
	endtask

	function automatic void put_write(input logic [CFG_IDX_BITS-1:0] idx,
			input logic [CFG_DATA_BITS-1:0] data);
		stim_row_t row;
		row.op = OP_WRITE;
		row.idx = idx;
		row.data = data;
		row.typed = 1'b0;
		row.res = ALL_ZERO;
		directed_rows.push_back(row);
	endfunction

	function automatic void put_item(input op_t op, input bit typed, input result_t res);
		stim_row_t row;
		row.op = op;
		row.idx = '0;
		row.data = '0;
		row.typed = typed;
		row.res = res;
		directed_rows.push_back(row);
	endfunction

	// Corners a fifth of the time; gentle values keep ramps and phases slow.
	function automatic logic [15:0] pick_word(input bit gentle);
		int unsigned r;
		r = $urandom_range(0, 9);
		if (r < 2) begin
			case ($urandom_range(0, 4))
				0: return 16'h0000;
				1: return 16'h0001;
				2: return 16'h7FFF;
				3: return 16'h8000;
				default: return 16'hFFFF;
			endcase
		end
		if (gentle && r < 6)
			return 16'($urandom_range(0, 128) - 64);
		return 16'($urandom);
	endfunction

	// ---------------------------------------------------------------------
	// Main sequence
	// ---------------------------------------------------------------------
	initial begin
		logic [1:0]  mode;
		int unsigned pick;
		arst_n = 1'b0;
		push <= 1'b0;
		restart <= 1'b0;
		wr_en <= 1'b0;
		wr_index <= '0;
		wr_data <= '0;
		mismatches = 0;
		cycles = 0;
		calm = 1'b0;
		hold_req = 1'b0;

		build_sine_lut();
		cfg_mode = RST_WAVE_MODE;
		cfg_level = longint'(RST_LEVEL);
		cfg_increment = longint'(RST_INCREMENT);
		cfg_lead = longint'(RST_LEAD);
		cfg_coef[0] = longint'(RST_COEF_FIRST);
		cfg_coef[1] = longint'(RST_COEF_SECOND);
		cfg_coef[2] = longint'(RST_COEF_THIRD);
		tick_count = '0;
		for (int c = 0; c < 2; c++)
			for (int s = 0; s < 3; s++)
				lag_state[c][s] = 0;

		// Directed table
		// out of reset: sine at phase zero is zero, chains still empty
		put_item(OP_TICK, 1'b1, ALL_ZERO);
		put_item(OP_TICK, 1'b0, ALL_ZERO);
		put_item(OP_TICK, 1'b0, ALL_ZERO);
		// step at full scale with frozen sections
		put_write(REG_WAVE_MODE, 16'(MODE_STEP));
		put_write(REG_LEVEL, 16'h7FFF);
		put_write(REG_COEF_FIRST, 16'h0000);
		put_write(REG_COEF_SECOND, 16'h0000);
		put_write(REG_COEF_THIRD, 16'h0000);
		put_item(OP_RESTART, 1'b0, ALL_ZERO);
		put_item(OP_TICK, 1'b1, result_t'({16'h7FFF, 16'h0000, 16'h0000}));
		// fastest sections
		put_write(REG_COEF_FIRST, 16'hFFFF);
		put_write(REG_COEF_SECOND, 16'hFFFF);
		put_write(REG_COEF_THIRD, 16'hFFFF);
		put_item(OP_TICK, 1'b0, ALL_ZERO);
		put_item(OP_TICK, 1'b0, ALL_ZERO);
		put_item(OP_TICK, 1'b0, ALL_ZERO);
		put_write(REG_LEVEL, 16'h8000);
		put_item(OP_TICK, 1'b0, ALL_ZERO);
		put_item(OP_TICK, 1'b0, ALL_ZERO);
		// ramp at the negative corner; the lead pushes the shifted copy into saturation
		put_write(REG_WAVE_MODE, 16'(MODE_RAMP));
		put_write(REG_LEVEL, 16'h8000);
		put_write(REG_INCREMENT, 16'h8000);
		put_write(REG_LEAD, 16'h8000);
		put_write(REG_COEF_FIRST, 16'h0000);
		put_write(REG_COEF_SECOND, 16'h0000);
		put_write(REG_COEF_THIRD, 16'h0000);
		put_item(OP_RESTART, 1'b0, ALL_ZERO);
		put_item(OP_TICK, 1'b1, result_t'({16'h8000, 16'h0000, 16'h0000}));
		// ramp at the positive corner, saturating from the first tick
		put_write(REG_LEVEL, 16'h7FFF);
		put_write(REG_INCREMENT, 16'h7FFF);
		put_write(REG_LEAD, 16'h7FFF);
		put_write(REG_COEF_FIRST, RST_COEF_FIRST);
		put_write(REG_COEF_SECOND, RST_COEF_SECOND);
		put_write(REG_COEF_THIRD, RST_COEF_THIRD);
		put_item(OP_TICK, 1'b0, ALL_ZERO);
		put_item(OP_TICK, 1'b0, ALL_ZERO);
		put_item(OP_TICK, 1'b0, ALL_ZERO);
		// negative full-scale sine in quarter turns: the trough saturates
		put_write(REG_WAVE_MODE, 16'(MODE_SINE));
		put_write(REG_LEVEL, 16'h8000);
		put_write(REG_INCREMENT, 16'h4000);
		put_write(REG_LEAD, 16'h4000);
		put_item(OP_TICK, 1'b0, ALL_ZERO);
		put_item(OP_TICK, 1'b0, ALL_ZERO);
		put_item(OP_TICK, 1'b0, ALL_ZERO);
		put_item(OP_TICK, 1'b0, ALL_ZERO);
		// unused mode yields nothing; a write past the map is dropped
		put_write(REG_WAVE_MODE, 16'(MODE_UNUSED));
		put_write(REG_UNMAPPED, 16'hFFFF);
		put_item(OP_TICK, 1'b0, ALL_ZERO);
		put_item(OP_RESTART, 1'b0, ALL_ZERO);
		// restart in sine mode brings phase and chains back to zero
		put_write(REG_WAVE_MODE, 16'(MODE_SINE));
		put_item(OP_TICK, 1'b0, ALL_ZERO);
		put_item(OP_RESTART, 1'b0, ALL_ZERO);
		put_item(OP_TICK, 1'b0, ALL_ZERO);

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int k = 0; k < directed_rows.size(); k++) begin
			if (directed_rows[k].op == OP_WRITE) begin
				// registers only change while the core is quiet
				if (k == 0 || directed_rows[k - 1].op != OP_WRITE)
					settle();
				write_reg(directed_rows[k].idx, directed_rows[k].data);
			end else begin
				send_item(directed_rows[k].op == OP_RESTART, directed_rows[k].typed,
					directed_rows[k].res);
			end
		end

		// Random phases: fresh settings, then a run of mostly normal ticks
		for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
			settle();
			calm = (phase >= RANDOM_PHASES - CALM_PHASES);
			pick = $urandom_range(0, 9);
			if (pick < 4)
				mode = MODE_SINE;
			else if (pick < 6)
				mode = MODE_STEP;
			else if (pick < 9)
				mode = MODE_RAMP;
			else
				mode = MODE_UNUSED;
			// the long hold-off needs a mode that yields samples
			if (phase == HOLD_PHASE && mode == MODE_UNUSED)
				mode = MODE_RAMP;
			write_reg(REG_WAVE_MODE, 16'(mode));
			if ($urandom_range(0, 3) != 0)
				write_reg(REG_LEVEL, pick_word(1'b0));
			if ($urandom_range(0, 3) != 0)
				write_reg(REG_INCREMENT, pick_word(1'b1));
			if ($urandom_range(0, 3) != 0)
				write_reg(REG_LEAD, pick_word(1'b1));
			if ($urandom_range(0, 1) != 0)
				write_reg(REG_COEF_FIRST, pick_word(1'b0));
			if ($urandom_range(0, 1) != 0)
				write_reg(REG_COEF_SECOND, pick_word(1'b0));
			if ($urandom_range(0, 1) != 0)
				write_reg(REG_COEF_THIRD, pick_word(1'b0));
			if ($urandom_range(0, 1) != 0)
				send_item(1'b1, 1'b0, ALL_ZERO);
			if (phase == HOLD_PHASE)
				hold_req = 1'b1;
			repeat (mode == MODE_UNUSED ? UNUSED_ITEMS : PHASE_ITEMS)
				send_item($urandom_range(0, 24) == 0, 1'b0, ALL_ZERO);
		end

		settle();
		if (mismatches == 0 && pending_samples.size() == 0)
			$display("tb_waveform_through_third_order_lag_core passed");
		else
			$display("tb_waveform_through_third_order_lag_core failed");
		$finish;
	end

endmodule

FILE: waveform_through_third_order_lag_core.f
+incdir+rtl
rtl/wftol_pkg.sv
rtl/wftol_queue.sv
rtl/wftol_front.sv
rtl/wftol_back.sv
rtl/waveform_through_third_order_lag_core.sv
bench/tb_waveform_through_third_order_lag_core.sv
